// ----- design/video_chip_cpu_register_port_assert.svh -----
// Assertion macros used by the register port design file.
`ifndef VIDEO_CHIP_CPU_REGISTER_PORT_ASSERT_SVH
`define VIDEO_CHIP_CPU_REGISTER_PORT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define VCCRP_ASSERT_IMP(lbl, clk_s, rst_s, a, b) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define VCCRP_ASSERT_NEXT(lbl, clk_s, rst_s, a, b) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (a) |=> (b)) \
    else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define VCCRP_ASSERT_ALWAYS(lbl, clk_s, a, b) \
  lbl: assert property (@(posedge clk_s) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- design/vccrp_pkg.sv -----
`default_nettype none
package vccrp_pkg;

  typedef enum logic [2:0] {
    KIND_WRITE     = 3'd0,
    KIND_READ      = 3'd1,
    KIND_VBL_ON    = 3'd2,
    KIND_VBL_OFF   = 3'd3,
    KIND_SPR_FLAGS = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REG_CTRL_A   = 3'd0,
    REG_CTRL_B   = 3'd1,
    REG_STATUS   = 3'd2,
    REG_SPR_ADDR = 3'd3,
    REG_SPR_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_sel_t;

  localparam logic [5:0]  PALETTE_PAGE  = 6'h3F;
  localparam logic [7:0]  SPR_FILL      = 8'hFF;
  localparam logic [7:0]  STATUS_KEEP   = 8'h60;
  localparam logic [7:0]  VBL_OFF_MASK  = 8'h3F;
  localparam logic [15:0] STEP_ONE      = 16'd1;
  localparam logic [15:0] STEP_ROW      = 16'd32;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        mem_write;
    logic        palette_write;
    logic [13:0] mem_addr;
    logic [7:0]  mem_wdata;
    logic [15:0] video_address;
    logic [14:0] temp_address;
    logic [2:0]  fine_x;
    logic [7:0]  control_a;
    logic [7:0]  control_b;
    logic        vblank_irq;
  } result_t;

endpackage
`default_nettype wire

// ----- design/vccrp_ram.sv -----
`default_nettype none
module vccrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/vccrp_out_buf.sv -----
`default_nettype none
module vccrp_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire vccrp_pkg::result_t push_data,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output vccrp_pkg::result_t     out_data,
  output logic                   full
);

  logic               main_valid;
  vccrp_pkg::result_t main_data;
  logic               skid_valid;
  vccrp_pkg::result_t skid_data;
  logic               pop;

  assign pop       = main_valid && !out_stall;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop && skid_valid) begin
      main_data  <= skid_data;
      skid_valid <= 1'b0;
    end else if (pop || !main_valid) begin
      main_valid <= push;
      if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- design/video_chip_cpu_register_port.sv -----
// CPU register port of a picture chip: eight registers, sprite memory,
// scroll and video address latches.
// Input channel (in_valid / in_stall) carries one event per transfer: a CPU
// write or read, vblank on, vblank off or a sprite-flag report. Output
// channel (out_valid / out_stall) returns one result per event: the read
// byte, the external video or palette memory request, and register values.
// Config channel (cfg_valid / cfg_ready) writes the security byte; ready is
// always high. The user must send writes only while the block is idle; the block itself does not enforce it.
// The result of an accepted event is registered in the output buffer. Throughput: one
// event per cycle while in_stall is low, set by the register update and the one
// write/one read port of the sprite memory.
// A two-entry output buffer lets the input keep going while a result waits;
// in_stall rises only when both entries hold results the receiver has not
// taken.
// Reset (rst, synchronous) clears all registers, sets the address step to
// one and empties the output buffer. Sprite memory is not cleared.
`default_nettype none
`include "video_chip_cpu_register_port_assert.svh"
module video_chip_cpu_register_port #(
  parameter int SPRITE_MEM_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [2:0]  reg_addr,
  input  wire logic [7:0]  data,
  input  wire logic        rendering,
  input  wire logic        chr_writable,
  input  wire logic [7:0]  mem_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       read_data,
  output logic             mem_write,
  output logic             palette_write,
  output logic [13:0]      mem_addr,
  output logic [7:0]       mem_wdata,
  output logic [15:0]      video_address,
  output logic [14:0]      temp_address,
  output logic [2:0]       fine_x,
  output logic [7:0]       control_a,
  output logic [7:0]       control_b,
  output logic             vblank_irq,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  localparam int SPR_AW = $clog2(SPRITE_MEM_DEPTH);

  logic        accept;
  logic [7:0]  security;
  logic [7:0]  ctrl_a,       ctrl_a_next;
  logic [7:0]  ctrl_b,       ctrl_b_next;
  logic [7:0]  status,       status_next;
  logic [7:0]  sprite_ptr,   sprite_ptr_next;
  logic        second_write, second_write_next;
  logic [7:0]  bus_latch,    bus_latch_next;
  logic [7:0]  read_buffer,  read_buffer_next;
  logic        step_row,     step_row_next;
  logic [14:0] temp_addr,    temp_addr_next;
  logic [15:0] video_addr,   video_addr_next;
  logic [2:0]  scroll_fine,  scroll_fine_next;

  logic        spr_we;
  logic [7:0]  spr_wdata;
  logic [7:0]  spr_rdata;

  vccrp_pkg::result_t res;
  vccrp_pkg::result_t out_res;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      security <= '0;
    end else if (cfg_valid && cfg_ready) begin
      security <= cfg_data;
    end
  end

  always_comb begin
    vccrp_pkg::reg_sel_t rsel;
    logic [7:0]  d_eff;
    logic [13:0] va;
    logic        pal;
    logic [15:0] step;

    ctrl_a_next       = ctrl_a;
    ctrl_b_next       = ctrl_b;
    status_next       = status;
    sprite_ptr_next   = sprite_ptr;
    second_write_next = second_write;
    bus_latch_next    = bus_latch;
    read_buffer_next  = read_buffer;
    step_row_next     = step_row;
    temp_addr_next    = temp_addr;
    video_addr_next   = video_addr;
    scroll_fine_next  = scroll_fine;
    spr_we            = 1'b0;
    res               = '0;

    rsel  = vccrp_pkg::reg_sel_t'(reg_addr);
    va    = video_addr[13:0];
    pal   = (va[13:8] == vccrp_pkg::PALETTE_PAGE);
    step  = step_row ? vccrp_pkg::STEP_ROW : vccrp_pkg::STEP_ONE;
    d_eff = data;

    if (accept) begin
      unique case (vccrp_pkg::kind_t'(kind))
        vccrp_pkg::KIND_WRITE: begin
          if (security != 8'd0 && reg_addr[2:1] == 2'b00) begin
            rsel = vccrp_pkg::reg_sel_t'({reg_addr[2:1], ~reg_addr[0]});
          end
          if (rsel == vccrp_pkg::REG_SPR_DATA && rendering) begin
            d_eff = vccrp_pkg::SPR_FILL;
          end
          unique case (rsel)
            vccrp_pkg::REG_CTRL_A: begin
              ctrl_a_next           = d_eff;
              temp_addr_next[11:10] = d_eff[1:0];
              step_row_next         = d_eff[2];
            end
            vccrp_pkg::REG_CTRL_B: begin
              ctrl_b_next = d_eff;
            end
            vccrp_pkg::REG_STATUS: begin
            end
            vccrp_pkg::REG_SPR_ADDR: begin
              sprite_ptr_next = d_eff;
            end
            vccrp_pkg::REG_SPR_DATA: begin
              spr_we          = 1'b1;
              sprite_ptr_next = sprite_ptr + 8'd1;
            end
            vccrp_pkg::REG_SCROLL: begin
              if (second_write) begin
                temp_addr_next[9:5]   = d_eff[7:3];
                temp_addr_next[14:12] = d_eff[2:0];
              end else begin
                temp_addr_next[4:0] = d_eff[7:3];
                scroll_fine_next    = d_eff[2:0];
              end
              second_write_next = !second_write;
            end
            vccrp_pkg::REG_ADDR: begin
              if (second_write) begin
                temp_addr_next[7:0] = d_eff;
                video_addr_next     = {1'b0, temp_addr[14:8], d_eff};
              end else begin
                temp_addr_next[14:8] = {1'b0, d_eff[5:0]};
              end
              second_write_next = !second_write;
            end
            vccrp_pkg::REG_DATA: begin
              res.mem_addr      = va;
              res.mem_wdata     = d_eff;
              res.palette_write = pal;
              res.mem_write     = !pal && chr_writable;
              video_addr_next   = video_addr + step;
            end
          endcase
          bus_latch_next = d_eff;
        end
        vccrp_pkg::KIND_READ: begin
          case (rsel)
            vccrp_pkg::REG_STATUS: begin
              if (security != 8'd0) begin
                bus_latch_next = {status[7:6], 6'd0} | security;
              end else begin
                bus_latch_next = status | {3'd0, bus_latch[4:0]};
              end
              second_write_next = 1'b0;
              if (bus_latch_next[7]) begin
                status_next = status & vccrp_pkg::STATUS_KEEP;
              end
              res.read_data = bus_latch_next;
            end
            vccrp_pkg::REG_SPR_DATA: begin
              bus_latch_next = spr_rdata;
              res.read_data  = spr_rdata;
            end
            vccrp_pkg::REG_DATA: begin
              res.mem_addr    = va;
              video_addr_next = video_addr + step;
              if (pal) begin
                res.read_data = mem_data;
              end else begin
                bus_latch_next   = read_buffer;
                read_buffer_next = mem_data;
                res.read_data    = read_buffer;
              end
            end
            default: begin
              res.read_data = bus_latch;
            end
          endcase
        end
        vccrp_pkg::KIND_VBL_ON: begin
          status_next = status | 8'h80;
        end
        vccrp_pkg::KIND_VBL_OFF: begin
          status_next = status & vccrp_pkg::VBL_OFF_MASK;
        end
        vccrp_pkg::KIND_SPR_FLAGS: begin
          status_next = status | (data & vccrp_pkg::STATUS_KEEP);
        end
        default: begin
        end
      endcase
    end

    spr_wdata         = d_eff;
    res.video_address = video_addr_next;
    res.temp_address  = temp_addr_next;
    res.fine_x        = scroll_fine_next;
    res.control_a     = ctrl_a_next;
    res.control_b     = ctrl_b_next;
    res.vblank_irq    = status_next[7] & ctrl_a_next[7];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_a       <= '0;
      ctrl_b       <= '0;
      status       <= '0;
      sprite_ptr   <= '0;
      second_write <= 1'b0;
      bus_latch    <= '0;
      read_buffer  <= '0;
      step_row     <= 1'b0;
      temp_addr    <= '0;
      video_addr   <= '0;
      scroll_fine  <= '0;
    end else begin
      ctrl_a       <= ctrl_a_next;
      ctrl_b       <= ctrl_b_next;
      status       <= status_next;
      sprite_ptr   <= sprite_ptr_next;
      second_write <= second_write_next;
      bus_latch    <= bus_latch_next;
      read_buffer  <= read_buffer_next;
      step_row     <= step_row_next;
      temp_addr    <= temp_addr_next;
      video_addr   <= video_addr_next;
      scroll_fine  <= scroll_fine_next;
    end
  end

  // read port follows the pointer of the next cycle so the data is ready
  vccrp_ram #(
    .WIDTH (8),
    .DEPTH (SPRITE_MEM_DEPTH)
  ) u_sprite_mem (
    .clk   (clk),
    .we    (spr_we),
    .waddr (sprite_ptr[SPR_AW-1:0]),
    .wdata (spr_wdata),
    .raddr (sprite_ptr_next[SPR_AW-1:0]),
    .rdata (spr_rdata)
  );

  vccrp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_res),
    .full      (in_stall)
  );

  assign read_data     = out_res.read_data;
  assign mem_write     = out_res.mem_write;
  assign palette_write = out_res.palette_write;
  assign mem_addr      = out_res.mem_addr;
  assign mem_wdata     = out_res.mem_wdata;
  assign video_address = out_res.video_address;
  assign temp_address  = out_res.temp_address;
  assign fine_x        = out_res.fine_x;
  assign control_a     = out_res.control_a;
  assign control_b     = out_res.control_b;
  assign vblank_irq    = out_res.vblank_irq;

  `VCCRP_ASSERT_IMP(a_stall_needs_result, clk, rst, in_stall, out_valid)
  `VCCRP_ASSERT_IMP(a_one_mem_target, clk, rst, out_valid, !(mem_write && palette_write))
  `VCCRP_ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, out_valid)
  `VCCRP_ASSERT_ALWAYS(a_empty_after_reset, clk, rst, !out_valid && !in_stall)

endmodule
`default_nettype wire
